FILE: hw/rtl/stress_tensor_rotation_macros.svh
// ----------------------------------------------------------------------------
// Stress tensor rotation assertion macros
// Shared assertion forms for the rotation block, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef STRESS_TENSOR_ROTATION_MACROS_SVH
`define STRESS_TENSOR_ROTATION_MACROS_SVH

// Checked only while the block is out of reset.
`define STRO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included.
`define STRO_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/stro_pkg.sv
// ----------------------------------------------------------------------------
// Stress tensor rotation package
// Number formats, payload types, register indices, rounding and clip helpers.
// ----------------------------------------------------------------------------
package stro_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC   = 16;
	localparam int COEF_W = FRAC + 2;
	localparam int DIM    = 3;
	localparam int ROW_W  = DIM * COEF_W;
	localparam int N_OUT  = 6;

	localparam int P1_W   = DATA_W + COEF_W;
	localparam int SUM1_W = P1_W + 2;
	localparam int T_W    = SUM1_W - FRAC;
	localparam int P2_W   = T_W + COEF_W;
	localparam int SUM2_W = P2_W + 2;
	localparam int R_W    = SUM2_W - FRAC;
	localparam int HALF   = 1 << (FRAC - 1);

	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_TRANSPOSE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_LEFT_ROW0  = 3'd1;
	localparam logic [IDX_W-1:0] REG_LEFT_ROW1  = 3'd2;
	localparam logic [IDX_W-1:0] REG_LEFT_ROW2  = 3'd3;
	localparam logic [IDX_W-1:0] REG_RIGHT_ROW0 = 3'd4;
	localparam logic [IDX_W-1:0] REG_RIGHT_ROW1 = 3'd5;
	localparam logic [IDX_W-1:0] REG_RIGHT_ROW2 = 3'd6;

	// Rows and columns of the rotated tensor reported in each output slot.
	localparam int OUT_ROW [N_OUT] = '{0, 1, 2, 2, 0, 1};
	localparam int OUT_COL [N_OUT] = '{0, 1, 2, 0, 1, 2};

	typedef logic signed [DATA_W-1:0] stress_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [T_W-1:0]    tval_t;
	typedef logic signed [R_W-1:0]    rval_t;

	typedef coef_t [DIM-1:0][DIM-1:0] coef_mat_t;
	typedef tval_t [DIM-1:0][DIM-1:0] tmat_t;

	typedef struct packed {
		coef_mat_t left;
		coef_mat_t right;
	} coef_set_t;

	typedef struct packed {
		stress_t s_xx;
		stress_t s_yy;
		stress_t s_zz;
		stress_t s_zx;
		stress_t s_xy;
		stress_t s_yz;
	} stress_in_t;

	typedef struct packed {
		stress_t r_xx;
		stress_t r_yy;
		stress_t r_zz;
		stress_t r_zx;
		stress_t r_xy;
		stress_t r_yz;
		logic    saturated;
	} stress_out_t;

	typedef struct packed {
		logic    sat;
		stress_t val;
	} clip_t;

	localparam stress_t STRESS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam stress_t STRESS_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	function automatic tval_t round_t(input logic signed [SUM1_W-1:0] x);
		logic signed [SUM1_W-1:0] h;
		h = x + SUM1_W'(HALF);
		return h[SUM1_W-1:FRAC];
	endfunction

	function automatic rval_t round_r(input logic signed [SUM2_W-1:0] x);
		logic signed [SUM2_W-1:0] h;
		h = x + SUM2_W'(HALF);
		return h[SUM2_W-1:FRAC];
	endfunction

	function automatic clip_t clip_out(input rval_t v);
		clip_t c;
		c.sat = (v[R_W-1:DATA_W-1] != {(R_W-DATA_W+1){v[R_W-1]}});
		if (c.sat) begin
			c.val = v[R_W-1] ? STRESS_MIN : STRESS_MAX;
		end else begin
			c.val = v[DATA_W-1:0];
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/stro_cfg_regs.sv
// ----------------------------------------------------------------------------
// Stress tensor rotation configuration registers
// Holds mode bit and matrix rows, unpacked; if transposing, left is right^T.
// ----------------------------------------------------------------------------
`include "stress_tensor_rotation_macros.svh"

module stro_cfg_regs
	import stro_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0] cfg_wdata,
	output coef_set_t        coefs
);

	localparam logic [ROW_W-1:0] ONE = ROW_W'(1) << FRAC;

	logic             transpose_q;
	logic [ROW_W-1:0] left_q  [DIM];
	logic [ROW_W-1:0] right_q [DIM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transpose_q <= 1'b1;
			for (int i = 0; i < DIM; i++) begin
				left_q[i]  <= ONE << (i * COEF_W);
				right_q[i] <= ONE << (i * COEF_W);
			end
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_TRANSPOSE:  transpose_q <= cfg_wdata[0];
				REG_LEFT_ROW0:  left_q[0]   <= cfg_wdata;
				REG_LEFT_ROW1:  left_q[1]   <= cfg_wdata;
				REG_LEFT_ROW2:  left_q[2]   <= cfg_wdata;
				REG_RIGHT_ROW0: right_q[0]  <= cfg_wdata;
				REG_RIGHT_ROW1: right_q[1]  <= cfg_wdata;
				REG_RIGHT_ROW2: right_q[2]  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < DIM; i++) begin
			for (int j = 0; j < DIM; j++) begin
				coefs.right[i][j] = right_q[i][j*COEF_W +: COEF_W];
			end
		end
		for (int i = 0; i < DIM; i++) begin
			for (int j = 0; j < DIM; j++) begin
				if (transpose_q) begin
					coefs.left[i][j] = right_q[j][i*COEF_W +: COEF_W];
				end else begin
					coefs.left[i][j] = left_q[i][j*COEF_W +: COEF_W];
				end
			end
		end
	end

	`STRO_ASSERT(a_mode_write, cfg_wen && cfg_index == REG_TRANSPOSE |=> transpose_q == $past(cfg_wdata[0]), "Mode write was not taken.")

endmodule

FILE: hw/rtl/stro_right_mul.sv
// ----------------------------------------------------------------------------
// Stress tensor rotation right product
// Two pipeline stages forming T = S * R with rounding to the wider T format.
// ----------------------------------------------------------------------------
`include "stress_tensor_rotation_macros.svh"

module stro_right_mul
	import stro_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  stress_in_t in_data,
	input  coef_mat_t  right,
	output logic       t_valid,
	input  logic       t_ready,
	output tmat_t      t_data
);

	stress_t smat [DIM][DIM];
	coef_t   rm   [DIM][DIM];

	logic                     v_s1;
	logic signed [P1_W-1:0]   prod_s1 [DIM][DIM][DIM];
	logic                     v_s2;
	tmat_t                    t_s2;
	tmat_t                    t_next;
	logic                     en_s1;
	logic                     en_s2;

	assign en_s2    = !v_s2 || t_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign t_valid  = v_s2;
	assign t_data   = t_s2;

	always_comb begin
		smat[0][0] = in_data.s_xx;
		smat[1][1] = in_data.s_yy;
		smat[2][2] = in_data.s_zz;
		smat[2][0] = in_data.s_zx;
		smat[0][2] = in_data.s_zx;
		smat[0][1] = in_data.s_xy;
		smat[1][0] = in_data.s_xy;
		smat[1][2] = in_data.s_yz;
		smat[2][1] = in_data.s_yz;
		for (int i = 0; i < DIM; i++) begin
			for (int j = 0; j < DIM; j++) begin
				rm[i][j] = right[i][j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < DIM; i++) begin
			for (int j = 0; j < DIM; j++) begin
				t_next[i][j] = round_t(SUM1_W'(prod_s1[i][j][0]) + SUM1_W'(prod_s1[i][j][1])
					+ SUM1_W'(prod_s1[i][j][2]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			for (int i = 0; i < DIM; i++) begin
				for (int j = 0; j < DIM; j++) begin
					for (int k = 0; k < DIM; k++) begin
						prod_s1[i][j][k] <= smat[i][k] * rm[k][j];
					end
				end
			end
		end
		if (en_s2 && v_s1) begin
			t_s2 <= t_next;
		end
	end

	`STRO_ASSERT(a_t_hold, v_s2 && !t_ready |=> v_s2 && $stable(t_s2), "Stalled tensor stage changed.")

endmodule

FILE: hw/rtl/stro_left_mul.sv
// ----------------------------------------------------------------------------
// Stress tensor rotation left product
// Two pipeline stages forming the six reported entries of L * T, rounded
// and saturated, with the saturation flag.
// ----------------------------------------------------------------------------
`include "stress_tensor_rotation_macros.svh"

module stro_left_mul
	import stro_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        t_valid,
	output logic        t_ready,
	input  tmat_t       t_data,
	input  coef_mat_t   left,
	output logic        out_valid,
	input  logic        out_ready,
	output stress_out_t out_data
);

	coef_t lm [DIM][DIM];
	tval_t tm [DIM][DIM];

	logic                   v_s3;
	logic signed [P2_W-1:0] prod_s3 [N_OUT][DIM];
	logic                   v_s4;
	stress_out_t            out_s4;
	stress_out_t            out_next;
	clip_t                  res [N_OUT];
	logic                   en_s3;
	logic                   en_s4;
	logic                   on_rail;

	assign en_s4     = !v_s4 || out_ready;
	assign en_s3     = !v_s3 || en_s4;
	assign t_ready   = en_s3;
	assign out_valid = v_s4;
	assign out_data  = out_s4;

	always_comb begin
		for (int i = 0; i < DIM; i++) begin
			for (int j = 0; j < DIM; j++) begin
				lm[i][j] = left[i][j];
				tm[i][j] = t_data[i][j];
			end
		end
	end

	always_comb begin
		for (int o = 0; o < N_OUT; o++) begin
			res[o] = clip_out(round_r(SUM2_W'(prod_s3[o][0]) + SUM2_W'(prod_s3[o][1])
				+ SUM2_W'(prod_s3[o][2])));
		end
		out_next.r_xx      = res[0].val;
		out_next.r_yy      = res[1].val;
		out_next.r_zz      = res[2].val;
		out_next.r_zx      = res[3].val;
		out_next.r_xy      = res[4].val;
		out_next.r_yz      = res[5].val;
		out_next.saturated = res[0].sat | res[1].sat | res[2].sat
			| res[3].sat | res[4].sat | res[5].sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= t_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && t_valid) begin
			for (int o = 0; o < N_OUT; o++) begin
				for (int k = 0; k < DIM; k++) begin
					prod_s3[o][k] <= lm[OUT_ROW[o]][k] * tm[k][OUT_COL[o]];
				end
			end
		end
		if (en_s4 && v_s3) begin
			out_s4 <= out_next;
		end
	end

	// A clipped result must leave at least one entry on a rail of the range.
	assign on_rail = (out_s4.r_xx == STRESS_MAX) || (out_s4.r_xx == STRESS_MIN)
		|| (out_s4.r_yy == STRESS_MAX) || (out_s4.r_yy == STRESS_MIN)
		|| (out_s4.r_zz == STRESS_MAX) || (out_s4.r_zz == STRESS_MIN)
		|| (out_s4.r_zx == STRESS_MAX) || (out_s4.r_zx == STRESS_MIN)
		|| (out_s4.r_xy == STRESS_MAX) || (out_s4.r_xy == STRESS_MIN)
		|| (out_s4.r_yz == STRESS_MAX) || (out_s4.r_yz == STRESS_MIN);

	`STRO_ASSERT(a_sat_on_rail, v_s4 && out_s4.saturated |-> on_rail, "Saturation flag without a clipped entry.")

endmodule

FILE: hw/rtl/stress_tensor_rotation.sv
// ----------------------------------------------------------------------------
// Stress tensor rotation
// Rotates a six-slot symmetric stress column as L * S * R in fixed point.
// ----------------------------------------------------------------------------
// The block takes one stress column per cycle while its output is not stalled
// and passes each column through four registered stages. The four stages
// are the 27 products of S * R, their sums rounded into T, the 18 products of
// L with the needed columns of T, and the final sums with rounding and
// saturation. Configuration writes take effect on the next cycle and should
// only be made while no column is in flight.
`include "stress_tensor_rotation_macros.svh"

module stress_tensor_rotation
	import stro_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  stress_in_t       in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output stress_out_t      out_data,
	input  logic             cfg_wen,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0] cfg_wdata
);

	coef_set_t coefs;
	logic      t_valid;
	logic      t_ready;
	tmat_t     t_data;

	stro_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.coefs     (coefs)
	);

	stro_right_mul u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.right    (coefs.right),
		.t_valid  (t_valid),
		.t_ready  (t_ready),
		.t_data   (t_data)
	);

	stro_left_mul u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.t_valid   (t_valid),
		.t_ready   (t_ready),
		.t_data    (t_data),
		.left      (coefs.left),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`STRO_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |=> !out_valid && !t_valid, "Valid seen during reset.")

endmodule
